/* hdl/kphl_pkg.sv */
// Shared constants for the keyword perfect-hash lookup block.
package kphl_pkg;

  // Default sizing
  localparam int TABLE_SLOTS_DEF     = 256;
  localparam int MAX_KEYWORD_LEN_DEF = 16;

  // Beat field widths
  localparam int MODE_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int SLOT_W  = 8;
  localparam int POS_W   = 4;
  localparam int ELEN_W  = 5;
  localparam int TYPE_W  = 8;
  localparam int HASH_W  = 32;

  // Beat modes
  localparam logic [MODE_W-1:0] MODE_LOOKUP      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE_CHAR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE_ENTRY = 2'd2;

  // FNV-1a and fmix32 constants
  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_MULT  = 32'd16777619;
  localparam logic [HASH_W-1:0] FMIX_C1   = 32'h85ebca6b;
  localparam logic [HASH_W-1:0] FMIX_C2   = 32'hc2b2ae35;

  // Seed register reset value
  localparam logic [HASH_W-1:0] SEED_RESET = 32'd1;

endpackage

/* hdl/kphl_fmix.sv */
// Two-stage fmix32 finaliser applied to hash xor seed.
module kphl_fmix (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic [kphl_pkg::HASH_W-1:0]  hash_in,
  input  logic [kphl_pkg::HASH_W-1:0]  seed,
  output logic                         done,
  output logic [kphl_pkg::HASH_W-1:0]  mix
);

  logic [kphl_pkg::HASH_W-1:0] x0;
  logic [kphl_pkg::HASH_W-1:0] x1;
  logic [kphl_pkg::HASH_W-1:0] p1;
  logic [kphl_pkg::HASH_W-1:0] y1;
  logic [kphl_pkg::HASH_W-1:0] p2;
  logic [kphl_pkg::HASH_W-1:0] m1_r;
  logic [kphl_pkg::HASH_W-1:0] m2_r;
  logic                        v1_r;
  logic                        v2_r;

  // First xor-shift and multiply
  assign x0 = hash_in ^ seed;
  assign x1 = x0 ^ (x0 >> 16);
  assign p1 = x1 * kphl_pkg::FMIX_C1;

  // Second xor-shift and multiply
  assign y1 = m1_r ^ (m1_r >> 13);
  assign p2 = y1 * kphl_pkg::FMIX_C2;

  always_ff @(posedge clk) begin
    m1_r <= p1;
    m2_r <= p2;
  end

  // Valid travels alongside the two product registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= go;
      v2_r <= v1_r;
    end
  end

  // Final xor-shift
  assign mix  = m2_r ^ (m2_r >> 16);
  assign done = v2_r;

endmodule

/* hdl/keyword_perfect_hash_lookup_core.sv */
// Sequence: a non-final lookup byte or a table write leaves busy low; a final byte gives its
//   result after two fmix multiply stages, a slot read and the length check, which ends the
//   lookup when it fails; else the stored spelling is then compared one byte per cycle until
//   a mismatch or its last byte.
// Throughput: one beat per cycle while busy is low; busy holds from the final byte to its result.
// Reset: synchronous active low; a clearing pass then empties all TABLE_SLOTS slots, one slot
//   a cycle, with busy high. The result strobe is a single cycle and cannot be stalled.
module keyword_perfect_hash_lookup_core #(
  parameter int TABLE_SLOTS     = kphl_pkg::TABLE_SLOTS_DEF,
  parameter int MAX_KEYWORD_LEN = kphl_pkg::MAX_KEYWORD_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic [kphl_pkg::MODE_W-1:0]  in_mode,
  input  logic [kphl_pkg::CHAR_W-1:0]  in_char_code,
  input  logic                         in_last_char,
  input  logic [kphl_pkg::SLOT_W-1:0]  in_slot,
  input  logic [kphl_pkg::POS_W-1:0]   in_position,
  input  logic [kphl_pkg::ELEN_W-1:0]  in_entry_length,
  input  logic [kphl_pkg::TYPE_W-1:0]  in_entry_type,
  // result channel
  output logic                         out_valid,
  output logic                         out_is_keyword,
  output logic [kphl_pkg::TYPE_W-1:0]  out_token_type,
  output logic [kphl_pkg::SLOT_W-1:0]  out_slot_index,
  // seed register
  input  logic                         cfg_we,
  input  logic [kphl_pkg::HASH_W-1:0]  cfg_wdata
);

  localparam int SW    = $clog2(TABLE_SLOTS);
  localparam int IW    = $clog2(MAX_KEYWORD_LEN);
  localparam int LW    = $clog2(MAX_KEYWORD_LEN + 2);
  localparam int CDEP  = TABLE_SLOTS * MAX_KEYWORD_LEN;
  localparam int CAW   = $clog2(CDEP);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FIN   = 3'd2;
  localparam logic [2:0] ST_LEN   = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;

  typedef struct packed {
    logic [kphl_pkg::ELEN_W-1:0] len;
    logic [kphl_pkg::TYPE_W-1:0] ttype;
  } kphl_entry_t;

  // Control and datapath registers
  logic [2:0]                    state_r, state_nxt;
  logic [SW-1:0]                 clr_r, clr_nxt;
  logic [IW-1:0]                 cnt_r, cnt_nxt;
  logic [kphl_pkg::HASH_W-1:0]   hash_r, hash_nxt;
  logic [LW-1:0]                 ilen_r, ilen_nxt;
  logic [kphl_pkg::HASH_W-1:0]   seed_r;
  logic [SW-1:0]                 idx_r, idx_nxt;
  logic [kphl_pkg::ELEN_W-1:0]   elen_r, elen_nxt;
  logic [kphl_pkg::TYPE_W-1:0]   etype_r, etype_nxt;
  logic                          ov_r, ov_nxt;
  logic                          okw_r, okw_nxt;
  logic [kphl_pkg::TYPE_W-1:0]   otype_r, otype_nxt;
  logic [kphl_pkg::SLOT_W-1:0]   oslot_r, oslot_nxt;

  // Identifier buffer, slot entry memory, spelling memory
  logic [kphl_pkg::CHAR_W-1:0]   ident_chars [MAX_KEYWORD_LEN];
  kphl_entry_t                   ent_mem [TABLE_SLOTS];
  kphl_entry_t                   ent_q;
  logic [kphl_pkg::CHAR_W-1:0]   chr_mem [CDEP];
  logic [kphl_pkg::CHAR_W-1:0]   chr_q;

  logic                          accept;
  logic                          acc_lookup;
  logic                          slot_ok;
  logic                          pos_ok;
  logic [kphl_pkg::HASH_W-1:0]   hash_step;
  logic                          fmix_done;
  logic [kphl_pkg::HASH_W-1:0]   fmix_mix;
  logic [SW-1:0]                 idx_raw;
  logic [SW-1:0]                 idx_calc;
  logic                          ent_we;
  logic [SW-1:0]                 ent_wa;
  kphl_entry_t                   ent_wd;
  logic [IW-1:0]                 rd_cnt;
  logic [CAW-1:0]                chr_ra;
  logic [CAW-1:0]                chr_wa;
  logic                          len_ok;
  logic                          last_byte;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign acc_lookup = accept && (in_mode == kphl_pkg::MODE_LOOKUP);
  assign slot_ok    = (32'(in_slot) < TABLE_SLOTS);
  assign pos_ok     = (32'(in_position) < MAX_KEYWORD_LEN);

  // FNV-1a step on the incoming byte
  assign hash_step = (hash_r ^ {{(kphl_pkg::HASH_W-kphl_pkg::CHAR_W){1'b0}}, in_char_code})
                     * kphl_pkg::FNV_MULT;

  // Finaliser runs on the settled hash, which includes the final byte
  kphl_fmix u_fmix (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (state_r == ST_FIN),
    .hash_in (hash_r),
    .seed    (seed_r),
    .done    (fmix_done),
    .mix     (fmix_mix)
  );

  // Slot from the finalised hash
  assign idx_raw  = fmix_mix[SW-1:0] & SW'(TABLE_SLOTS - 1);
  assign idx_calc = (32'(idx_raw) < TABLE_SLOTS) ? idx_raw : '0;

  // Entry memory: clearing pass or table entry write, read at the hashed slot
  assign ent_we = (state_r == ST_CLEAR) ||
                  (accept && (in_mode == kphl_pkg::MODE_WRITE_ENTRY) && slot_ok);
  assign ent_wa = (state_r == ST_CLEAR) ? clr_r : SW'(in_slot);
  always_comb begin
    ent_wd       = '0;
    if (state_r != ST_CLEAR) begin
      ent_wd.len   = in_entry_length;
      ent_wd.ttype = in_entry_type;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    ent_q <= ent_mem[idx_calc];
  end

  // Spelling memory: next byte to compare is prefetched in the cycle before its compare
  assign rd_cnt = ((state_r == ST_CMP) && (32'(cnt_r) < MAX_KEYWORD_LEN - 1)) ?
                  IW'(32'(cnt_r) + 32'd1) : '0;
  assign chr_ra = CAW'(idx_r) * CAW'(MAX_KEYWORD_LEN) + CAW'(rd_cnt);
  assign chr_wa = CAW'(in_slot) * CAW'(MAX_KEYWORD_LEN) + CAW'(in_position);

  always_ff @(posedge clk) begin
    if (accept && (in_mode == kphl_pkg::MODE_WRITE_CHAR) && slot_ok && pos_ok) begin
      chr_mem[chr_wa] <= in_char_code;
    end
    chr_q <= chr_mem[chr_ra];
  end

  // Identifier buffer keeps the first MAX_KEYWORD_LEN bytes
  always_ff @(posedge clk) begin
    if (acc_lookup && (32'(ilen_r) < MAX_KEYWORD_LEN)) begin
      ident_chars[ilen_r[IW-1:0]] <= in_char_code;
    end
  end

  assign len_ok    = (ent_q.len != '0) && (32'(ent_q.len) <= MAX_KEYWORD_LEN) &&
                     (32'(ent_q.len) == 32'(ilen_r));
  assign last_byte = ((32'(cnt_r) + 32'd1) == 32'(elen_r));

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    hash_nxt  = hash_r;
    ilen_nxt  = ilen_r;
    idx_nxt   = idx_r;
    elen_nxt  = elen_r;
    etype_nxt = etype_r;
    ov_nxt    = 1'b0;
    okw_nxt   = 1'b0;
    otype_nxt = '0;
    oslot_nxt = kphl_pkg::SLOT_W'(idx_r);
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = SW'(32'(clr_r) + 32'd1);
        if (32'(clr_r) == TABLE_SLOTS - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc_lookup) begin
          hash_nxt = hash_step;
          if (32'(ilen_r) <= MAX_KEYWORD_LEN) begin
            ilen_nxt = LW'(32'(ilen_r) + 32'd1);
          end
          if (in_last_char) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (fmix_done) begin
          idx_nxt   = idx_calc;
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        elen_nxt  = ent_q.len;
        etype_nxt = ent_q.ttype;
        cnt_nxt   = '0;
        if (len_ok) begin
          state_nxt = ST_CMP;
        end else begin
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
          hash_nxt  = kphl_pkg::FNV_BASIS;
          ilen_nxt  = '0;
        end
      end
      ST_CMP: begin
        if (chr_q != ident_chars[cnt_r]) begin
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
          hash_nxt  = kphl_pkg::FNV_BASIS;
          ilen_nxt  = '0;
        end else if (last_byte) begin
          ov_nxt    = 1'b1;
          okw_nxt   = 1'b1;
          otype_nxt = etype_r;
          state_nxt = ST_IDLE;
          hash_nxt  = kphl_pkg::FNV_BASIS;
          ilen_nxt  = '0;
        end else begin
          cnt_nxt = IW'(32'(cnt_r) + 32'd1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      hash_r  <= kphl_pkg::FNV_BASIS;
      ilen_r  <= '0;
      seed_r  <= kphl_pkg::SEED_RESET;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      hash_r  <= hash_nxt;
      ilen_r  <= ilen_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    idx_r   <= idx_nxt;
    elen_r  <= elen_nxt;
    etype_r <= etype_nxt;
    okw_r   <= okw_nxt;
    otype_r <= otype_nxt;
    oslot_r <= oslot_nxt;
  end

  assign out_valid      = ov_r;
  assign out_is_keyword = okw_r;
  assign out_token_type = otype_r;
  assign out_slot_index = oslot_r;

endmodule

/* hdl/kphl_checker.sv */
// Port-level checks for the keyword lookup core, bound to the top level.
module kphl_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [kphl_pkg::MODE_W-1:0]  in_mode,
  input  logic                         in_last_char,
  input  logic                         out_valid,
  input  logic                         out_is_keyword,
  input  logic [kphl_pkg::TYPE_W-1:0]  out_token_type
);

  // Reset starts the slot clearing pass
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  // A final lookup byte always engages the lookup sequence
  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_mode == kphl_pkg::MODE_LOOKUP) && in_last_char |=> busy)
    else $error("final byte did not start a lookup");

  // Results are never back to back and always end a busy stretch
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beats back to back");

  a_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a preceding lookup");

  // A miss carries no type code
  a_miss_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_keyword |-> out_token_type == '0)
    else $error("type code on a miss");

endmodule

bind keyword_perfect_hash_lookup_core kphl_checker u_kphl_checker (.*);

/* test/keyword_perfect_hash_lookup_core_tb.sv */
// Self-checking testbench for the keyword perfect-hash lookup core.
`timescale 1ns / 1ps

module keyword_perfect_hash_lookup_core_tb;

  localparam int SLOTS          = kphl_pkg::TABLE_SLOTS_DEF;
  localparam int KW_MAX         = kphl_pkg::MAX_KEYWORD_LEN_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RAND_BEATS     = 360;
  localparam int PHASE_BEATS    = 90;

  // beat field widths and modes
  localparam int MODE_W = kphl_pkg::MODE_W;
  localparam int CHAR_W = kphl_pkg::CHAR_W;
  localparam int SLOT_W = kphl_pkg::SLOT_W;
  localparam int POS_W  = kphl_pkg::POS_W;
  localparam int ELEN_W = kphl_pkg::ELEN_W;
  localparam int TYPE_W = kphl_pkg::TYPE_W;
  localparam int HASH_W = kphl_pkg::HASH_W;

  localparam logic [MODE_W-1:0] MODE_LOOKUP      = kphl_pkg::MODE_LOOKUP;
  localparam logic [MODE_W-1:0] MODE_WRITE_CHAR  = kphl_pkg::MODE_WRITE_CHAR;
  localparam logic [MODE_W-1:0] MODE_WRITE_ENTRY = kphl_pkg::MODE_WRITE_ENTRY;

  // mode 3 has no meaning in the block and must be dropped
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  position;
    logic [ELEN_W-1:0] entry_length;
    logic [TYPE_W-1:0] entry_type;
  } beat_t;

  typedef struct packed {
    logic              is_keyword;
    logic [TYPE_W-1:0] token_type;
    logic [SLOT_W-1:0] slot_index;
  } lookup_result_t;

  // identifier of up to 24 bytes
  typedef struct packed {
    logic [23:0][7:0] ch;
    logic [4:0]       len;
  } word_t;

  // directed row: at_last takes the slot of the latest lookup, rep repeats the beat
  // with last_char only on the final copy, typed carries a hand-written verdict
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
    logic              at_last;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  position;
    logic [ELEN_W-1:0] entry_length;
    logic [TYPE_W-1:0] entry_type;
    logic [4:0]        rep;
    logic              typed;
    logic              kw;
    logic [TYPE_W-1:0] ty;
  } dir_row_t;

  dir_row_t directed_rows [16] = '{
    // ignored mode, every field at its top value
    '{MODE_UNUSED,      8'hff, 1'b1, 1'b0, 8'hff, 4'hf, 5'd31, 8'hff, 5'd1, 1'b0, 1'b0, 8'h00},
    // "k" into an empty table
    '{MODE_LOOKUP,      8'h6b, 1'b1, 1'b0, 8'h00, 4'h0, 5'd0,  8'h00, 5'd1, 1'b1, 1'b0, 8'h00},
    // load "k" into the slot it hashed to, then hit it
    '{MODE_WRITE_CHAR,  8'h6b, 1'b0, 1'b1, 8'h00, 4'h0, 5'd0,  8'h00, 5'd1, 1'b0, 1'b0, 8'h00},
    '{MODE_WRITE_ENTRY, 8'h00, 1'b0, 1'b1, 8'h00, 4'h0, 5'd1,  8'hff, 5'd1, 1'b0, 1'b0, 8'h00},
    '{MODE_LOOKUP,      8'h6b, 1'b1, 1'b0, 8'h00, 4'h0, 5'd0,  8'h00, 5'd1, 1'b1, 1'b1, 8'hff},
    // stored length beyond the keyword limit
    '{MODE_WRITE_ENTRY, 8'h00, 1'b0, 1'b1, 8'h00, 4'h0, 5'd31, 8'h5a, 5'd1, 1'b0, 1'b0, 8'h00},
    '{MODE_LOOKUP,      8'h6b, 1'b1, 1'b0, 8'h00, 4'h0, 5'd0,  8'h00, 5'd1, 1'b1, 1'b0, 8'h00},
    // same length, different spelling
    '{MODE_WRITE_CHAR,  8'h6a, 1'b0, 1'b1, 8'h00, 4'h0, 5'd0,  8'h00, 5'd1, 1'b0, 1'b0, 8'h00},
    '{MODE_WRITE_ENTRY, 8'h00, 1'b0, 1'b1, 8'h00, 4'h0, 5'd1,  8'h01, 5'd1, 1'b0, 1'b0, 8'h00},
    '{MODE_LOOKUP,      8'h6b, 1'b1, 1'b0, 8'h00, 4'h0, 5'd0,  8'h00, 5'd1, 1'b1, 1'b0, 8'h00},
    // table writes in the middle of "ab"
    '{MODE_LOOKUP,      8'h61, 1'b0, 1'b0, 8'h00, 4'h0, 5'd0,  8'h00, 5'd1, 1'b0, 1'b0, 8'h00},
    '{MODE_WRITE_CHAR,  8'haa, 1'b0, 1'b0, 8'hff, 4'hf, 5'd0,  8'h00, 5'd1, 1'b0, 1'b0, 8'h00},
    '{MODE_WRITE_ENTRY, 8'h00, 1'b0, 1'b0, 8'h80, 4'h0, 5'd0,  8'h00, 5'd1, 1'b0, 1'b0, 8'h00},
    '{MODE_LOOKUP,      8'h62, 1'b1, 1'b0, 8'h00, 4'h0, 5'd0,  8'h00, 5'd1, 1'b1, 1'b0, 8'h00},
    // overlong: sixteen zero bytes then 0xff
    '{MODE_LOOKUP,      8'h00, 1'b0, 1'b0, 8'h00, 4'h0, 5'd0,  8'h00, 5'd16, 1'b0, 1'b0, 8'h00},
    '{MODE_LOOKUP,      8'hff, 1'b1, 1'b0, 8'h00, 4'h0, 5'd0,  8'h00, 5'd1, 1'b1, 1'b0, 8'h00}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [MODE_W-1:0]   in_mode;
  logic [CHAR_W-1:0]   in_char_code;
  logic                in_last_char;
  logic [SLOT_W-1:0]   in_slot;
  logic [POS_W-1:0]    in_position;
  logic [ELEN_W-1:0]   in_entry_length;
  logic [TYPE_W-1:0]   in_entry_type;
  logic                out_valid;
  logic                out_is_keyword;
  logic [TYPE_W-1:0]   out_token_type;
  logic [SLOT_W-1:0]   out_slot_index;
  logic                cfg_we;
  logic [HASH_W-1:0]   cfg_wdata;

  // shadow of the block: seed, identifier in flight and slot table
  logic [HASH_W-1:0]   seed_q;
  logic [HASH_W-1:0]   id_hash;
  logic [4:0]          id_len;
  logic [7:0]          id_buf [KW_MAX];
  logic [7:0]          tbl_chars [SLOTS][KW_MAX];
  logic [KW_MAX-1:0]   tbl_written [SLOTS];
  logic [ELEN_W-1:0]   tbl_len [SLOTS];
  logic [TYPE_W-1:0]   tbl_type [SLOTS];
  logic [SLOT_W-1:0]   last_slot;

  lookup_result_t      expected_results [$];
  word_t               keywords [$];

  int  mismatches = 0;
  int  n_beats = 0;
  int  n_lookups = 0;
  int  n_hits = 0;
  int  n_seeds = 0;
  int  stall_cycles = 0;
  bit  no_idle = 1'b0;

  keyword_perfect_hash_lookup_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_char_code   (in_char_code),
    .in_last_char   (in_last_char),
    .in_slot        (in_slot),
    .in_position    (in_position),
    .in_entry_length(in_entry_length),
    .in_entry_type  (in_entry_type),
    .out_valid      (out_valid),
    .out_is_keyword (out_is_keyword),
    .out_token_type (out_token_type),
    .out_slot_index (out_slot_index),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  // fmix32 finaliser
  function automatic logic [31:0] fmix(input logic [31:0] h);
    h = h ^ (h >> 16);
    h = h * kphl_pkg::FMIX_C1;
    h = h ^ (h >> 13);
    h = h * kphl_pkg::FMIX_C2;
    h = h ^ (h >> 16);
    return h;
  endfunction

  // slot a whole identifier lands in under the current seed
  function automatic logic [SLOT_W-1:0] slot_of(input word_t w);
    logic [31:0] h;
    logic [31:0] f;
    h = kphl_pkg::FNV_BASIS;
    for (int i = 0; i < w.len; i++) h = (h ^ {24'd0, w.ch[i]}) * kphl_pkg::FNV_MULT;
    f = fmix(h ^ seed_q);
    return f[SLOT_W-1:0];
  endfunction

  // advance the shadow by one accepted beat; a final lookup byte yields a result
  function automatic void predict_beat(input beat_t b, output bit has_res,
                                       output lookup_result_t r);
    logic [31:0]       f;
    logic [SLOT_W-1:0] idx;
    logic [ELEN_W-1:0] slen;
    bit                hit;
    has_res = 1'b0;
    r = '0;
    case (b.mode)
      MODE_WRITE_CHAR: begin
        tbl_chars[b.slot][b.position] = b.char_code;
        tbl_written[b.slot][b.position] = 1'b1;
      end
      MODE_WRITE_ENTRY: begin
        tbl_len[b.slot] = b.entry_length;
        tbl_type[b.slot] = b.entry_type;
      end
      MODE_LOOKUP: begin
        id_hash = (id_hash ^ {24'd0, b.char_code}) * kphl_pkg::FNV_MULT;
        if (id_len < KW_MAX) id_buf[id_len] = b.char_code;
        if (id_len <= KW_MAX) id_len = id_len + 1'b1;
        if (b.last_char) begin
          f = fmix(id_hash ^ seed_q);
          idx = f[SLOT_W-1:0];
          slen = tbl_len[idx];
          hit = (slen != 0) && (slen <= KW_MAX) && (slen == id_len);
          for (int i = 0; i < KW_MAX; i++)
            if (hit && i < slen && tbl_chars[idx][i] != id_buf[i]) hit = 1'b0;
          r.is_keyword = hit;
          r.token_type = hit ? tbl_type[idx] : '0;
          r.slot_index = idx;
          last_slot = idx;
          has_res = 1'b1;
          id_hash = kphl_pkg::FNV_BASIS;
          id_len = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // number of spelling bytes written in a row from position 0
  function automatic int spelled(input logic [SLOT_W-1:0] s);
    int n;
    n = 0;
    for (int i = 0; i < KW_MAX; i++)
      if (n == i && tbl_written[s][i]) n = i + 1;
    return n;
  endfunction

  // entry length that never exposes an unwritten spelling byte
  function automatic logic [ELEN_W-1:0] safe_len(input logic [SLOT_W-1:0] s);
    int k;
    k = spelled(s);
    case ($urandom % 4)
      0: return '0;
      1: return ELEN_W'($urandom_range(KW_MAX + 1, 31));
      default: return (k == 0) ? '0 : ELEN_W'($urandom_range(1, k));
    endcase
  endfunction

  function automatic beat_t junk_beat(input logic [MODE_W-1:0] m);
    beat_t b;
    b = beat_t'({$urandom, $urandom});
    b.mode = m;
    return b;
  endfunction

  function automatic word_t random_word(input int lo, input int hi);
    word_t w;
    w = '0;
    w.len = 5'($urandom_range(lo, hi));
    for (int i = 0; i < w.len; i++)
      w.ch[i] = ($urandom % 10 < 7) ? 8'h61 + 8'($urandom % 26) : 8'($urandom);
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom % 100;
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic idle(input int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // present one beat and hold it until the block takes it
  task automatic drive_beat(input beat_t b, input bit typed, input bit t_kw,
                            input logic [TYPE_W-1:0] t_ty);
    bit             has_res;
    lookup_result_t r;
    @(negedge clk);
    start = 1'b1;
    in_mode = b.mode;
    in_char_code = b.char_code;
    in_last_char = b.last_char;
    in_slot = b.slot;
    in_position = b.position;
    in_entry_length = b.entry_length;
    in_entry_type = b.entry_type;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_beat(b, has_res, r);
    if (b.mode != MODE_UNUSED) n_beats++;
    if (has_res) begin
      if (typed) begin
        r.is_keyword = t_kw;
        r.token_type = t_ty;
      end
      expected_results.push_back(r);
      n_lookups++;
      if (r.is_keyword) n_hits++;
    end
  endtask

  task automatic send(input beat_t b);
    idle(pick_gap());
    drive_beat(b, 1'b0, 1'b0, '0);
  endtask

  task automatic drain();
    do idle(1); while (expected_results.size() != 0);
    idle(6);
  endtask

  task automatic write_seed(input logic [HASH_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    seed_q = v;
    n_seeds++;
  endtask

  task automatic spell_into(input word_t w, input logic [SLOT_W-1:0] s, input int n);
    beat_t b;
    for (int i = 0; i < n; i++) begin
      b = junk_beat(MODE_WRITE_CHAR);
      b.slot = s;
      b.position = POS_W'(i);
      b.char_code = w.ch[i];
      send(b);
    end
  endtask

  task automatic set_entry(input logic [SLOT_W-1:0] s, input int len);
    beat_t b;
    b = junk_beat(MODE_WRITE_ENTRY);
    b.slot = s;
    b.entry_length = ELEN_W'(len);
    send(b);
  endtask

  task automatic noise_write();
    beat_t b;
    if ($urandom % 2) begin
      send(junk_beat(MODE_WRITE_CHAR));
    end else begin
      b = junk_beat(MODE_WRITE_ENTRY);
      b.entry_length = safe_len(b.slot);
      send(b);
    end
  endtask

  // identifier bytes, now and then with a table write slipped in between
  task automatic send_word(input word_t w);
    beat_t b;
    for (int i = 0; i < w.len; i++) begin
      if ($urandom % 10 == 0) noise_write();
      b = junk_beat(MODE_LOOKUP);
      b.char_code = w.ch[i];
      b.last_char = (i == w.len - 1);
      send(b);
    end
  endtask

  task automatic random_op();
    word_t             w;
    word_t             x;
    logic [SLOT_W-1:0] s;
    int                r;
    int                k;
    beat_t             b;
    if ($urandom % 16 == 0) no_idle = !no_idle;
    r = $urandom % 100;
    if (r < 25) begin
      // new keyword placed where it hashes
      w = random_word(1, ($urandom % 4 == 0) ? KW_MAX : 6);
      s = slot_of(w);
      spell_into(w, s, w.len);
      set_entry(s, w.len);
      keywords.push_back(w);
      if (keywords.size() > 32) void'(keywords.pop_front());
    end else if (r < 65) begin
      // known keyword, exact or slightly altered
      w = (keywords.size() != 0) ? keywords[$urandom % keywords.size()] : random_word(1, 6);
      if (r >= 55) begin
        if ($urandom % 2) begin
          k = $urandom % w.len;
          w.ch[k] = w.ch[k] ^ 8'($urandom_range(1, 255));
        end else if (w.len > 1 && ($urandom % 2)) begin
          w.len = w.len - 1'b1;
        end else if (w.len < KW_MAX) begin
          w.ch[w.len] = 8'($urandom);
          w.len = w.len + 1'b1;
        end
      end
      send_word(w);
    end else if (r < 73) begin
      send_word(random_word(1, KW_MAX));
    end else if (r < 80) begin
      // overlong identifier, sometimes with a tempting entry at its slot
      w = random_word(KW_MAX + 1, 24);
      s = slot_of(w);
      k = $urandom % 3;
      if (k == 1) begin
        set_entry(s, ($urandom % 2) ? KW_MAX + 1 : $urandom_range(KW_MAX + 2, 31));
      end else if (k == 2) begin
        spell_into(w, s, KW_MAX);
        set_entry(s, KW_MAX);
      end
      send_word(w);
    end else if (r < 88) begin
      // occupied slot that must not match
      w = random_word(1, 8);
      s = slot_of(w);
      k = $urandom % 3;
      if (k == 0) begin
        x = w;
        r = $urandom % w.len;
        x.ch[r] = x.ch[r] ^ 8'($urandom_range(1, 255));
        spell_into(x, s, x.len);
        set_entry(s, w.len);
      end else if (k == 1) begin
        spell_into(w, s, w.len);
        b = junk_beat(MODE_WRITE_CHAR);
        b.slot = s;
        b.position = POS_W'(w.len);
        send(b);
        set_entry(s, w.len + 1);
      end else begin
        set_entry(s, $urandom_range(KW_MAX + 1, 31));
      end
      send_word(w);
    end else if (r < 94) begin
      noise_write();
    end else begin
      send(junk_beat(MODE_UNUSED));
    end
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: keyword %0b type %0h slot %0h", $time,
                 out_is_keyword, out_token_type, out_slot_index);
      end else begin
        want = expected_results.pop_front();
        if (out_is_keyword !== want.is_keyword) begin
          mismatches++;
          $display("%0t: is_keyword expected %0b, got %0b", $time, want.is_keyword,
                   out_is_keyword);
        end
        if (out_token_type !== want.token_type) begin
          mismatches++;
          $display("%0t: token_type expected %0h, got %0h", $time, want.token_type,
                   out_token_type);
        end
        if (out_slot_index !== want.slot_index) begin
          mismatches++;
          $display("%0t: slot_index expected %0h, got %0h", $time, want.slot_index,
                   out_slot_index);
        end
      end
    end
  end

  // watchdog on cycles with no beat and no result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid === 1'b1) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("keyword_perfect_hash_lookup_core_tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    beat_t b;
    int    base_beats;
    int    phase;
    int    phase_start;
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = '0;
    in_char_code = '0;
    in_last_char = 1'b0;
    in_slot = '0;
    in_position = '0;
    in_entry_length = '0;
    in_entry_type = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    seed_q = kphl_pkg::SEED_RESET;
    id_hash = kphl_pkg::FNV_BASIS;
    id_len = '0;
    last_slot = '0;
    for (int i = 0; i < KW_MAX; i++) id_buf[i] = '0;
    for (int s = 0; s < SLOTS; s++) begin
      tbl_written[s] = '0;
      tbl_len[s] = '0;
      tbl_type[s] = '0;
      for (int i = 0; i < KW_MAX; i++) tbl_chars[s][i] = '0;
    end

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    // let the table clearing pass finish
    do idle(1); while (busy !== 1'b0);

    // directed rows under the reset seed
    foreach (directed_rows[n]) begin
      b.mode = directed_rows[n].mode;
      b.char_code = directed_rows[n].char_code;
      b.slot = directed_rows[n].at_last ? last_slot : directed_rows[n].slot;
      b.position = directed_rows[n].position;
      b.entry_length = directed_rows[n].entry_length;
      b.entry_type = directed_rows[n].entry_type;
      for (int k = 0; k < directed_rows[n].rep; k++) begin
        b.last_char = directed_rows[n].last_char && (k == directed_rows[n].rep - 1);
        idle(pick_gap());
        drive_beat(b, directed_rows[n].typed && (k == directed_rows[n].rep - 1),
                   directed_rows[n].kw, directed_rows[n].ty);
      end
    end

    // random phases, each under its own seed
    base_beats = n_beats;
    phase = 0;
    while (n_beats - base_beats < RAND_BEATS) begin
      case (phase)
        0: write_seed('0);
        1: write_seed('1);
        default: write_seed($urandom);
      endcase
      keywords.delete();
      phase_start = n_beats;
      while (n_beats - phase_start < PHASE_BEATS) random_op();
      phase++;
    end

    drain();
    idle(20);
    $display("Covered %0d beats and %0d lookups (%0d keyword hits) over %0d seed writes,",
             n_beats, n_lookups, n_hits, n_seeds);
    $display("with overlong names, empty and oversized slots and writes inside lookups.");
    if (mismatches == 0) begin
      $display("keyword_perfect_hash_lookup_core_tb passed");
    end else begin
      $display("keyword_perfect_hash_lookup_core_tb failed");
    end
    $finish;
  end

endmodule
